// ----- sv/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants of the sorted insert stack
// Holds the default sizes, the operation and status codes, the controller
// states and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_POP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_val;     // capture the incoming value
    logic    push_top;     // write the value on top, it is the new smallest
    logic    start_shift;  // read the top entry to begin the insertion walk
    logic    shift_step;   // move the read entry up one slot, read the next one
    logic    place;        // write the value at the insertion slot
    logic    pop_last;     // remove the only entry
    logic    pop_read;     // read the entry below the top
    logic    pop_load;     // take the read entry as the new top
    logic    finish;       // present a result next cycle
    status_t code;         // status of that result
  } sis_cmd_t;

  // Flags from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic count_one;
    logic val_on_top;      // incoming value is not above the current top
    logic rd_lt_val;       // read entry is strictly smaller than the value
    logic idx_zero;        // the walk has reached the bottom entry
  } sis_flags_t;

endpackage

// ----- sv/sis_ctrl.sv -----
// ----------------------------------------------------------------------------
// sis_ctrl: controller of the sorted insert stack
// Sequences pushes, the insertion walk and pops, and issues datapath commands.
// ----------------------------------------------------------------------------
module sis_ctrl
  import sis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       opcode,
  input  sis_flags_t flags,
  output sis_cmd_t   cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_PUSH) begin
            if (!flags.full && !flags.val_on_top) begin
              state_next = ST_SHIFT;
            end
          end else if (!flags.empty && !flags.count_one) begin
            state_next = ST_POP;
          end
        end
      end
      ST_SHIFT: begin
        if (flags.rd_lt_val) begin
          if (flags.idx_zero) begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PLACE: state_next = ST_IDLE;
      ST_POP:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.code = STATUS_OK;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_val = 1'b1;
          if (opcode == OP_PUSH) begin
            if (flags.full) begin
              cmd.finish = 1'b1;
              cmd.code   = STATUS_FULL;
            end else if (flags.val_on_top) begin
              cmd.push_top = 1'b1;
              cmd.finish   = 1'b1;
            end else begin
              cmd.start_shift = 1'b1;
            end
          end else begin
            if (flags.empty) begin
              cmd.finish = 1'b1;
              cmd.code   = STATUS_EMPTY;
            end else if (flags.count_one) begin
              cmd.pop_last = 1'b1;
              cmd.finish   = 1'b1;
            end else begin
              cmd.pop_read = 1'b1;
            end
          end
        end
      end
      ST_SHIFT: begin
        if (flags.rd_lt_val) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.place  = 1'b1;
          cmd.finish = 1'b1;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        cmd.finish = 1'b1;
      end
      ST_POP: begin
        cmd.pop_load = 1'b1;
        cmd.finish   = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- sv/sis_datapath.sv -----
// ----------------------------------------------------------------------------
// sis_datapath: storage and result registers of the sorted insert stack
// Holds the entry memory, the fill count, the top register and the walk
// pointers, and registers each result for one cycle.
// ----------------------------------------------------------------------------
module sis_datapath
  import sis_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int COUNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  sis_cmd_t                     cmd,
  output sis_flags_t                   flags,
  output logic signed [DATA_WIDTH-1:0] top_value,
  output logic        [COUNT_W-1:0]    count,
  output logic                         empty_res,
  output logic        [1:0]            status,
  output logic                         done
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata;
  logic signed [DATA_WIDTH-1:0] val_q;
  logic signed [DATA_WIDTH-1:0] top;
  logic        [COUNT_W-1:0]    fill;
  logic        [AW-1:0]         idx;
  logic        [AW-1:0]         wr_ptr;
  status_t                      status_q;

  logic                         wr_en;
  logic        [AW-1:0]         wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic                         rd_en;
  logic        [AW-1:0]         rd_addr;
  logic        [COUNT_W-1:0]    fill_m1;
  logic        [COUNT_W-1:0]    fill_m2;

  assign fill_m1 = fill - COUNT_W'(1);
  assign fill_m2 = fill - COUNT_W'(2);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_ptr;
    wr_data = val_q;
    if (cmd.push_top) begin
      wr_en   = 1'b1;
      wr_addr = fill[AW-1:0];
      wr_data = value;
    end else if (cmd.shift_step) begin
      wr_en   = 1'b1;
      wr_data = rdata;
    end else if (cmd.place) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx - AW'(1);
    if (cmd.start_shift) begin
      rd_en   = 1'b1;
      rd_addr = fill_m1[AW-1:0];
    end else if (cmd.shift_step) begin
      rd_en   = (idx != '0);
    end else if (cmd.pop_read) begin
      rd_en   = 1'b1;
      rd_addr = fill_m2[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_val) begin
      val_q <= value;
    end
    if (cmd.push_top) begin
      top <= value;
    end else if (cmd.pop_load) begin
      top <= rdata;
    end
    if (cmd.start_shift) begin
      idx    <= fill_m1[AW-1:0];
      wr_ptr <= fill[AW-1:0];
    end else if (cmd.shift_step) begin
      wr_ptr <= idx;
      if (idx != '0) begin
        idx <= idx - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      done     <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      if (cmd.push_top || cmd.place) begin
        fill <= fill + COUNT_W'(1);
      end else if (cmd.pop_last || cmd.pop_load) begin
        fill <= fill_m1;
      end
      done <= cmd.finish;
      if (cmd.finish) begin
        status_q <= cmd.code;
      end
    end
  end

  assign flags.full       = (fill == COUNT_W'(DEPTH));
  assign flags.empty      = (fill == '0);
  assign flags.count_one  = (fill == COUNT_W'(1));
  assign flags.val_on_top = (fill == '0) || (value <= top);
  assign flags.rd_lt_val  = (rdata < val_q);
  assign flags.idx_zero   = (idx == '0);

  assign top_value = (fill == '0) ? '0 : top;
  assign count     = fill;
  assign empty_res = (fill == '0);
  assign status    = status_q;

endmodule

// ----- sv/sorted_insert_stack.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_stack: bounded stack kept sorted with the smallest value on top
// Accepts push and pop items and returns the top value, count, empty flag and
// status of each one.
// ----------------------------------------------------------------------------
// An item is accepted on a rising edge where start is high and busy is low.
// Exactly one result follows for every item: it sits on top_value, count,
// empty_res and status for the single cycle in which done is high, and the
// receiver has no way to hold it, so it must capture it in that cycle. A push
// places the value below every stored value that is strictly smaller, which
// puts it above any equal values; a pop removes the smallest value. A push on
// a full stack returns status 1 and a pop on an empty stack returns status 2,
// both with the contents unchanged. The entries live in a single-port-write,
// single-port-read memory with a registered read, and an insertion walks it
// one entry per cycle from the top down. A push whose value is not above the
// current top, a refused item and a pop of the last entry finish in the
// accept cycle and show their result in the next one. A pop that leaves
// entries first reads the new top from memory. A push that lands below the
// top moves each stored entry that is strictly smaller than the value up one
// slot and then writes the value into the slot freed last. busy stays high
// through this work, and done comes in the cycle after it ends, in which
// the next item may already be accepted. The memory needs no clearing after
// reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_insert_stack
  import sis_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int COUNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         opcode,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic                         busy,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] top_value,
  output logic        [COUNT_W-1:0]    count,
  output logic                         empty_res,
  output logic        [1:0]            status
);

  // Commands flow from the controller into the datapath, and the datapath
  // answers with comparison and fill flags.
  sis_cmd_t   cmd;
  sis_flags_t flags;

  sis_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .flags  (flags),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath owns the memory, the count, the top register and the
  // one-cycle result registers.
  sis_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .COUNT_W    (COUNT_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .flags     (flags),
    .top_value (top_value),
    .count     (count),
    .empty_res (empty_res),
    .status    (status),
    .done      (done)
  );

endmodule

// ----- sv/sis_checker.sv -----
// ----------------------------------------------------------------------------
// sis_checker: port-level checks of the sorted insert stack
// Watches the command and result ports over time and flags inconsistencies.
// ----------------------------------------------------------------------------
module sis_checker
  import sis_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int COUNT_W    = $clog2(DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic signed [DATA_WIDTH-1:0] top_value,
  input logic        [COUNT_W-1:0]    count,
  input logic                         empty_res,
  input logic        [1:0]            status
);

  // A result only follows an accepted item or a cycle of work on one.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start && !busy)))
    else $error("result without an item in flight");

  // A result is only shown once the work on its item is over.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  // The empty flag agrees with the count, and the count never exceeds DEPTH.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (empty_res == (count == '0)) && (count <= COUNT_W'(DEPTH)))
    else $error("empty flag or count out of line");

  // Refusals match the fill level they report.
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_FULL)) |-> (count == COUNT_W'(DEPTH)))
    else $error("full refusal with room left");

  assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_EMPTY)) |-> (count == '0) && (top_value == '0))
    else $error("empty refusal with entries stored");

endmodule

bind sorted_insert_stack sis_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH),
  .COUNT_W    (COUNT_W)
) u_sis_checker (.*);
